### hw/rtl/roman_numeral_encoder_macros.svh
// ----------------------------------------------------------------------------
// roman numeral encoder assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_MACROS_SVH

// same-cycle implication
`define RNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// types, microcode table and symbol tables for the roman numeral encoder
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned NumW  = 13;
  localparam int unsigned WgtW  = 12;
  localparam int unsigned SymW  = 7;
  localparam int unsigned StepW = 5;

  localparam logic [NumW-1:0] MaxValid = 13'd3999;

  localparam logic [SymW-1:0] SymI = 7'h49;
  localparam logic [SymW-1:0] SymV = 7'h56;
  localparam logic [SymW-1:0] SymX = 7'h58;
  localparam logic [SymW-1:0] SymL = 7'h4c;
  localparam logic [SymW-1:0] SymC = 7'h43;
  localparam logic [SymW-1:0] SymD = 7'h44;
  localparam logic [SymW-1:0] SymM = 7'h4d;
  localparam logic [SymW-1:0] SymNone = 7'h00;

  // place codes
  localparam logic [1:0] PlaceUnits = 2'd0;
  localparam logic [1:0] PlaceTens  = 2'd1;
  localparam logic [1:0] PlaceHund  = 2'd2;
  localparam logic [1:0] PlaceThou  = 2'd3;

  // pattern codes within a place
  localparam logic [1:0] CodeOne  = 2'd0;
  localparam logic [1:0] CodeFive = 2'd1;
  localparam logic [1:0] CodeTen  = 2'd2;

  // program addresses
  localparam logic [StepW-1:0] StepLoad  = 5'd0;
  localparam logic [StepW-1:0] StepCheck = 5'd1;
  localparam logic [StepW-1:0] StepT2000 = 5'd2;
  localparam logic [StepW-1:0] StepT1000 = 5'd3;
  localparam logic [StepW-1:0] StepH800  = 5'd4;
  localparam logic [StepW-1:0] StepH400  = 5'd5;
  localparam logic [StepW-1:0] StepH200  = 5'd6;
  localparam logic [StepW-1:0] StepH100  = 5'd7;
  localparam logic [StepW-1:0] StepE80   = 5'd8;
  localparam logic [StepW-1:0] StepE40   = 5'd9;
  localparam logic [StepW-1:0] StepE20   = 5'd10;
  localparam logic [StepW-1:0] StepE10   = 5'd11;
  localparam logic [StepW-1:0] StepUnits = 5'd12;
  localparam logic [StepW-1:0] StepEmitT = 5'd13;
  localparam logic [StepW-1:0] StepEmitH = 5'd14;
  localparam logic [StepW-1:0] StepEmitE = 5'd15;
  localparam logic [StepW-1:0] StepEmitU = 5'd16;
  localparam logic [StepW-1:0] StepError = 5'd17;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CMPSUB,
    OP_MOVU,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef enum logic [1:0] {
    CND_ALWAYS,
    CND_WAIT,
    CND_BRANCH
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [1:0]       place;
    logic [WgtW-1:0]  weight;
    logic [StepW-1:0] nxt;
    logic [StepW-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic go;      // current step may leave
    logic branch;  // branch condition
  } stat_t;

  function automatic ctrl_t mk(op_e op, cond_e cond, logic [1:0] place,
                               logic [WgtW-1:0] weight, logic [StepW-1:0] nxt,
                               logic [StepW-1:0] tgt);
    ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.place  = place;
    w.weight = weight;
    w.nxt    = nxt;
    w.tgt    = tgt;
    return w;
  endfunction

  // control store
  function automatic ctrl_t rom_word(logic [StepW-1:0] step);
    ctrl_t w;
    unique case (step)
      StepLoad:  w = mk(OP_LOAD, CND_WAIT, PlaceUnits, 12'd0, StepCheck, StepLoad);
      StepCheck: w = mk(OP_NOP, CND_BRANCH, PlaceUnits, 12'd0, StepT2000, StepError);
      StepT2000: w = mk(OP_CMPSUB, CND_ALWAYS, PlaceThou, 12'd2000, StepT1000, StepLoad);
      StepT1000: w = mk(OP_CMPSUB, CND_ALWAYS, PlaceThou, 12'd1000, StepH800, StepLoad);
      StepH800:  w = mk(OP_CMPSUB, CND_ALWAYS, PlaceHund, 12'd800, StepH400, StepLoad);
      StepH400:  w = mk(OP_CMPSUB, CND_ALWAYS, PlaceHund, 12'd400, StepH200, StepLoad);
      StepH200:  w = mk(OP_CMPSUB, CND_ALWAYS, PlaceHund, 12'd200, StepH100, StepLoad);
      StepH100:  w = mk(OP_CMPSUB, CND_ALWAYS, PlaceHund, 12'd100, StepE80, StepLoad);
      StepE80:   w = mk(OP_CMPSUB, CND_ALWAYS, PlaceTens, 12'd80, StepE40, StepLoad);
      StepE40:   w = mk(OP_CMPSUB, CND_ALWAYS, PlaceTens, 12'd40, StepE20, StepLoad);
      StepE20:   w = mk(OP_CMPSUB, CND_ALWAYS, PlaceTens, 12'd20, StepE10, StepLoad);
      StepE10:   w = mk(OP_CMPSUB, CND_ALWAYS, PlaceTens, 12'd10, StepUnits, StepLoad);
      StepUnits: w = mk(OP_MOVU, CND_ALWAYS, PlaceUnits, 12'd0, StepEmitT, StepLoad);
      StepEmitT: w = mk(OP_EMIT, CND_WAIT, PlaceThou, 12'd0, StepEmitH, StepLoad);
      StepEmitH: w = mk(OP_EMIT, CND_WAIT, PlaceHund, 12'd0, StepEmitE, StepLoad);
      StepEmitE: w = mk(OP_EMIT, CND_WAIT, PlaceTens, 12'd0, StepEmitU, StepLoad);
      StepEmitU: w = mk(OP_EMIT, CND_WAIT, PlaceUnits, 12'd0, StepLoad, StepLoad);
      StepError: w = mk(OP_ERR, CND_WAIT, PlaceUnits, 12'd0, StepLoad, StepLoad);
      default:   w = mk(OP_NOP, CND_ALWAYS, PlaceUnits, 12'd0, StepLoad, StepLoad);
    endcase
    return w;
  endfunction

  // symbols per digit
  function automatic logic [2:0] pat_len(logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] pat_code(logic [3:0] d, logic [1:0] idx);
    logic [1:0] c;
    c = CodeOne;
    case (d)
      4'd4:                   if (idx == 2'd1) c = CodeFive;
      4'd5, 4'd6, 4'd7, 4'd8: if (idx == 2'd0) c = CodeFive;
      4'd9:                   if (idx == 2'd1) c = CodeTen;
      default:                c = CodeOne;
    endcase
    return c;
  endfunction

  function automatic logic [SymW-1:0] place_sym(logic [1:0] place, logic [1:0] code);
    logic [SymW-1:0] s;
    case ({place, code})
      {PlaceUnits, CodeOne}:  s = SymI;
      {PlaceUnits, CodeFive}: s = SymV;
      {PlaceUnits, CodeTen}:  s = SymX;
      {PlaceTens, CodeOne}:   s = SymX;
      {PlaceTens, CodeFive}:  s = SymL;
      {PlaceTens, CodeTen}:   s = SymC;
      {PlaceHund, CodeOne}:   s = SymC;
      {PlaceHund, CodeFive}:  s = SymD;
      {PlaceHund, CodeTen}:   s = SymM;
      {PlaceThou, CodeOne}:   s = SymM;
      default:                s = SymNone;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/rne_sequencer.sv
// ----------------------------------------------------------------------------
// rne_sequencer
// step counter and control store; issues one control word per cycle
// ----------------------------------------------------------------------------
module rne_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rne_pkg::stat_t stat_i,
  output rne_pkg::ctrl_t ctrl_o
);
  import rne_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ctrl_t            word;

  always_comb begin
    word = rom_word(step_q);
  end

  always_comb begin
    case (word.cond)
      CND_ALWAYS: step_d = word.nxt;
      CND_WAIT:   step_d = stat_i.go ? word.nxt : step_q;
      CND_BRANCH: step_d = stat_i.branch ? word.tgt : word.nxt;
      default:    step_d = StepLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepLoad;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

endmodule

### hw/rtl/rne_datapath.sv
// ----------------------------------------------------------------------------
// rne_datapath
// digit extraction by compare-subtract, symbol lookup and output register
// ----------------------------------------------------------------------------
module rne_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rne_pkg::ctrl_t              ctrl_i,
  output rne_pkg::stat_t              stat_o,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rne_pkg::NumW-1:0]    number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rne_pkg::SymW-1:0]    symbol_o,
  output logic                        last_o,
  output logic                        error_o
);
  import rne_pkg::*;

  logic [NumW-1:0] rem_q;
  logic            bad_q;
  logic [3:0]      digit_q [4];
  logic [1:0]      idx_q;

  logic            out_valid_q;
  logic [SymW-1:0] sym_q;
  logic            last_q;
  logic            err_q;

  logic [3:0]      cur_digit;
  logic [2:0]      cur_len;
  logic [2:0]      idx_plus;
  logic            final_sym;
  logic            lower_zero;
  logic            slot_free;
  logic            emit_load;
  logic            err_load;
  logic            ge;
  logic [NumW-1:0] wgt;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cur_digit = digit_q[ctrl_i.place];
  assign cur_len   = pat_len(cur_digit);
  assign idx_plus  = {1'b0, idx_q} + 3'd1;
  assign final_sym = (idx_plus == cur_len);
  assign wgt       = {{(NumW-WgtW){1'b0}}, ctrl_i.weight};
  assign ge        = (rem_q >= wgt);

  // no symbols follow from lower places
  always_comb begin
    lower_zero = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < ctrl_i.place && digit_q[k] != 4'd0) lower_zero = 1'b0;
    end
  end

  assign emit_load = (ctrl_i.op == OP_EMIT) && (cur_len != 3'd0) && slot_free;
  assign err_load  = (ctrl_i.op == OP_ERR) && slot_free;

  always_comb begin
    stat_o.branch = bad_q;
    case (ctrl_i.op)
      OP_LOAD: stat_o.go = in_valid_i;
      OP_EMIT: stat_o.go = (cur_len == 3'd0) || (slot_free && final_sym);
      OP_ERR:  stat_o.go = slot_free;
      default: stat_o.go = 1'b1;
    endcase
  end

  assign in_ready_o = (ctrl_i.op == OP_LOAD);

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          rem_q <= number_i;
          bad_q <= (number_i == '0) || (number_i > MaxValid);
          for (int k = 0; k < 4; k++) digit_q[k] <= 4'd0;
        end
      end
      OP_CMPSUB: begin
        if (ge) rem_q <= rem_q - wgt;
        for (int k = 0; k < 4; k++) begin
          if (2'(k) == ctrl_i.place) digit_q[k] <= {digit_q[k][2:0], ge};
        end
      end
      OP_MOVU: begin
        digit_q[0] <= rem_q[3:0];
      end
      default: begin
      end
    endcase
  end

  // position within the current place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (emit_load) begin
      idx_q <= final_sym ? 2'd0 : idx_plus[1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load || err_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      sym_q  <= place_sym(ctrl_i.place, pat_code(cur_digit, idx_q));
      last_q <= final_sym && lower_zero;
      err_q  <= 1'b0;
    end else if (err_load) begin
      sym_q  <= SymNone;
      last_q <= 1'b1;
      err_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

### hw/rtl/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// converts an integer to its roman numeral as a stream of ascii letters
// ----------------------------------------------------------------------------
// usage:
//   slave stream: s_axis_tdata_i[12:0] carries the number; a transaction is
//   taken only while the sequencer sits in its load step.
//   master stream: one transaction per letter, thousands place first;
//   tdata[6:0] is the ascii code, tlast marks the final letter, tuser flags
//   a number of 0 or above 3999, which gives a single transaction with
//   symbol 0 and tlast set.
//   sequence: a valid number runs 13 fixed steps (load, range check, ten
//   compare-subtract steps, units move), then an emit step for each place,
//   thousands first, which issues that place's letters one at a time and
//   passes over a place that has no letters. an out-of-range number goes
//   from the range check to the error step, which issues the error letter.
//   the next number is taken while the last letter still waits in the
//   output register.
//   reset: the step counter returns to the load step and the output empties.
//   stall: when tready is low the emit step holds, letter by letter.
// ----------------------------------------------------------------------------
`include "roman_numeral_encoder_macros.svh"

module roman_numeral_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [12:0] number, [15:13] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] symbol, [7] zero
  output logic        m_axis_tlast_o,   // last_symbol
  output logic        m_axis_tuser_o    // range_error
);
  import rne_pkg::*;

  ctrl_t           ctrl;
  stat_t           stat;
  logic [SymW-1:0] symbol;

  rne_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  rne_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .number_i    (s_axis_tdata_i[NumW-1:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .symbol_o    (symbol),
    .last_o      (m_axis_tlast_o),
    .error_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, symbol};

  // error transaction is a lone zero symbol
  `RNE_ASSERT_IMP(a_err_form, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 8'd0 && m_axis_tlast_o, "error transaction malformed")
  // every normal letter is a real character
  `RNE_ASSERT_IMP(a_sym_nonzero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[6:0] != 7'd0, "normal transaction without a letter")
  // after taking a number the block is busy
  `RNE_ASSERT_NXT(a_busy_after_load, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input taken twice in a row")

endmodule

### tb/tb_roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// tb_roman_numeral_encoder
// self-checking bench: numbers go in on the slave stream, every letter out is
// compared with a roman numeral typed in the table or computed in the bench;
// a directed table covers extremes, subtractive digits and range errors,
// then random numbers follow, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_roman_numeral_encoder;
  import rne_pkg::*;

  localparam int unsigned RandomNumbers = 96;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned MaxGap        = 18;

  typedef struct {
    logic [SymW-1:0] symbol;
    logic            last_symbol;
    logic            range_error;
  } letter_t;

  typedef enum {
    ROW_PREDICT,
    ROW_LETTERS,
    ROW_RANGE_ERR
  } row_kind_e;

  typedef struct {
    logic [NumW-1:0] num;
    row_kind_e       kind;
    string           letters;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [12:0] number, [15:13] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [6:0] symbol, [7] zero
  logic        m_axis_tlast_o;        // last_symbol
  logic        m_axis_tuser_o;        // range_error

  letter_t     expected_letters[$];
  int unsigned fails = 0;
  int unsigned numbers_sent = 0;
  int unsigned letters_seen = 0;
  int unsigned range_errors_seen = 0;
  int unsigned idle_cycles = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  // typed rows as written, range-error rows as one error letter, the rest via the predictor
  row_t dir_rows [24] = '{
    '{13'd0,    ROW_RANGE_ERR, ""},
    '{13'd1,    ROW_LETTERS,   "I"},
    '{13'd3999, ROW_LETTERS,   "MMMCMXCIX"},
    '{13'd4000, ROW_RANGE_ERR, ""},
    '{13'd8191, ROW_RANGE_ERR, ""},
    '{13'd4096, ROW_RANGE_ERR, ""},
    '{13'd3888, ROW_LETTERS,   "MMMDCCCLXXXVIII"},
    '{13'd4,    ROW_LETTERS,   "IV"},
    '{13'd9,    ROW_LETTERS,   "IX"},
    '{13'd40,   ROW_LETTERS,   "XL"},
    '{13'd90,   ROW_LETTERS,   "XC"},
    '{13'd400,  ROW_LETTERS,   "CD"},
    '{13'd900,  ROW_LETTERS,   "CM"},
    '{13'd3000, ROW_LETTERS,   "MMM"},
    '{13'd5,    ROW_PREDICT,   ""},
    '{13'd8,    ROW_PREDICT,   ""},
    '{13'd50,   ROW_PREDICT,   ""},
    '{13'd500,  ROW_PREDICT,   ""},
    '{13'd1000, ROW_PREDICT,   ""},
    '{13'd2048, ROW_PREDICT,   ""},
    '{13'd14,   ROW_PREDICT,   ""},
    '{13'd444,  ROW_PREDICT,   ""},
    '{13'd999,  ROW_PREDICT,   ""},
    '{13'd1994, ROW_PREDICT,   ""}
  };

  roman_numeral_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  function automatic void push_letter(logic [SymW-1:0] sym, logic last_sym, logic err);
    letter_t l;
    l.symbol      = sym;
    l.last_symbol = last_sym;
    l.range_error = err;
    expected_letters.insert(expected_letters.size(), l);
  endfunction

  // queue the letters of one number, thousands first
  function automatic void push_numeral_letters(logic [NumW-1:0] num);
    int unsigned     rest;
    int unsigned     scale;
    int unsigned     digit;
    logic [SymW-1:0] one_sym;
    logic [SymW-1:0] five_sym;
    logic [SymW-1:0] ten_sym;
    if (num == '0 || num > MaxValid) begin
      push_letter(SymNone, 1'b1, 1'b1);
      return;
    end
    rest  = 32'(num);
    scale = 1000;
    for (int place = 3; place >= 0; place--) begin
      digit = rest / scale;
      rest  = rest % scale;
      case (place)
        3: begin
          one_sym = SymM; five_sym = SymNone; ten_sym = SymNone;
        end
        2: begin
          one_sym = SymC; five_sym = SymD; ten_sym = SymM;
        end
        1: begin
          one_sym = SymX; five_sym = SymL; ten_sym = SymC;
        end
        default: begin
          one_sym = SymI; five_sym = SymV; ten_sym = SymX;
        end
      endcase
      if (digit == 9) begin
        push_letter(one_sym, 1'b0, 1'b0);
        push_letter(ten_sym, 1'b0, 1'b0);
      end else if (digit == 4) begin
        push_letter(one_sym, 1'b0, 1'b0);
        push_letter(five_sym, 1'b0, 1'b0);
      end else begin
        if (digit >= 5) push_letter(five_sym, 1'b0, 1'b0);
        for (int unsigned k = 0; k < digit % 5; k++) push_letter(one_sym, 1'b0, 1'b0);
      end
      scale = scale / 10;
    end
    expected_letters[expected_letters.size()-1].last_symbol = 1'b1;
  endfunction

  // returns at the edge where the number was taken
  task automatic send_number(input logic [NumW-1:0] num);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, num};
    do @(posedge clk_i); while (!s_axis_tready_o);
    numbers_sent++;
  endtask

  initial begin
    logic [NumW-1:0] num;
    byte             ch;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_number(dir_rows[r].num);
      case (dir_rows[r].kind)
        ROW_LETTERS: begin
          for (int i = 0; i < dir_rows[r].letters.len(); i++) begin
            ch = dir_rows[r].letters[i];
            push_letter(ch[SymW-1:0], i == dir_rows[r].letters.len() - 1, 1'b0);
          end
        end
        ROW_RANGE_ERR: push_letter(SymNone, 1'b1, 1'b1);
        default:       push_numeral_letters(dir_rows[r].num);
      endcase
    end

    for (int unsigned i = 0; i < RandomNumbers; i++) begin
      if (i % 16 == 0) send_burst = ($urandom_range(0, 3) == 0);
      // mostly valid numbers, some zeros and values past the top of the range
      case ($urandom_range(0, 19))
        0:       num = '0;
        1, 2:    num = NumW'($urandom_range(4000, 8191));
        3, 4:    num = NumW'($urandom_range(1, 40));
        default: num = NumW'($urandom_range(1, 3999));
      endcase
      send_number(num);
      push_numeral_letters(num);
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d numbers (directed table plus random), %0d letters checked",
             numbers_sent, letters_seen);
    $display("%0d range error transactions, %0d mismatches", range_errors_seen, fails);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver side: random stalls before each letter
  initial begin
    int unsigned stall;
    int unsigned n;
    n = 0;
    forever begin
      if (n % 16 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && rst_ni));
      n++;
    end
  end

  always @(posedge clk_i) begin
    letter_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      letters_seen++;
      if (m_axis_tuser_o) range_errors_seen++;
      if (expected_letters.size() == 0) begin
        $error("unexpected letter transaction: symbol %h tlast %b tuser %b",
               m_axis_tdata_o[SymW-1:0], m_axis_tlast_o, m_axis_tuser_o);
        fails++;
      end else begin
        want = expected_letters.pop_front();
        if (m_axis_tdata_o[SymW-1:0] !== want.symbol) begin
          $error("symbol: expected %h, got %h", want.symbol, m_axis_tdata_o[SymW-1:0]);
          fails++;
        end
        if (m_axis_tlast_o !== want.last_symbol) begin
          $error("last_symbol: expected %b, got %b", want.last_symbol, m_axis_tlast_o);
          fails++;
        end
        if (m_axis_tuser_o !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, m_axis_tuser_o);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rne_pkg.sv
hw/rtl/rne_sequencer.sv
hw/rtl/rne_datapath.sv
hw/rtl/roman_numeral_encoder.sv
tb/tb_roman_numeral_encoder.sv
